// ===== hw/rtl/itoa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itoa_pkg
// Shared types, constants and a helper for the integer to ASCII converter.
// ----------------------------------------------------------------------------
package itoa_pkg;

    // Largest field width plus one for fixed-width decimal text
    localparam int MAX_WIDTH = 64;

    // Value and digit sizes
    localparam int VALUE_W = 32;
    localparam int DIG_W   = 6;                       // holds a digit below 36
    localparam int TXT_MAX = VALUE_W + 1;             // base 2 digits plus sign
    localparam int IDX_RANGE = (MAX_WIDTH > TXT_MAX) ? MAX_WIDTH : TXT_MAX + 1;
    localparam int IDX_W   = $clog2(IDX_RANGE);       // character index width
    localparam int NDIG_W  = $clog2(VALUE_W + 1);     // digit count width
    localparam int SLOT_W  = $clog2(VALUE_W);         // digit store index width

    // Request modes
    localparam logic [1:0] MODE_DEC   = 2'd0;
    localparam logic [1:0] MODE_FIXED = 2'd1;
    localparam logic [1:0] MODE_RADIX = 2'd2;

    // Radix limits
    localparam logic [7:0] RADIX_MIN = 8'd2;
    localparam logic [7:0] RADIX_MAX = 8'd36;
    localparam logic [DIG_W-1:0] DEC_BASE = DIG_W'(10);

    // Character codes
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_UPPER = 8'h41;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // Divider start request
    typedef struct packed {
        logic               start;
        logic [VALUE_W-1:0] dividend;
        logic [DIG_W-1:0]   divisor;
    } div_req_t;

    // Divider result
    typedef struct packed {
        logic               done;
        logic [VALUE_W-1:0] quotient;
        logic [DIG_W-1:0]   remainder;
    } div_rsp_t;

    // Digit value to ASCII, letters above nine
    function automatic logic [7:0] digit_char(input logic [DIG_W-1:0] d);
        logic [7:0] dw;
        dw = 8'(d);
        if (d < DIG_W'(10))
            return CH_ZERO + dw;
        else
            return CH_UPPER + dw - 8'd10;
    endfunction

endpackage

// ===== hw/rtl/itoa_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itoa_div
// Bit-serial restoring divider: 32-bit dividend by a small base, one
// quotient bit per cycle. Result is held after the done pulse.
// ----------------------------------------------------------------------------
module itoa_div
    import itoa_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    localparam int CNT_W = $clog2(VALUE_W);

    logic [VALUE_W-1:0] quo_reg, quo_next;
    logic [DIG_W-1:0]   rem_reg, rem_next;
    logic [DIG_W-1:0]   div_reg, div_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;

    logic [DIG_W:0] trial;
    logic [DIG_W:0] diff;
    logic           ge;

    // One restoring step
    always_comb
    begin
        trial = {rem_reg, quo_reg[VALUE_W-1]};
        ge    = (trial >= {1'b0, div_reg});
        diff  = trial - {1'b0, div_reg};
    end

    // Step sequencing
    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            quo_next  = req.dividend;
            rem_next  = '0;
            div_next  = req.divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[VALUE_W-2:0], ge};
            rem_next = ge ? diff[DIG_W-1:0] : trial[DIG_W-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(VALUE_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

// ===== hw/rtl/integer_to_ascii_converter_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_to_ascii_converter_unit
// Turns a 32-bit value into an ASCII character stream, most significant
// character first, in signed decimal, fixed-width decimal or any base 2..36.
//
// Input channel: in_valid / in_stall carry one request word (req_type,
// value_bits, radix, pad_width). in_stall is high while a request is being
// converted or emitted; a new request is taken once the last character has
// entered the output register.
// Output channel: out_valid / out_stall carry one character word per
// handshake, last_char marks the final character of a request. Requests with
// a bad width, bad base or unused mode are taken and produce no words.
// Digits come from one shared bit-serial divider, one full division per
// digit (32 quotient bits plus the handoff), then one character per cycle
// while the receiver does not stall.
// When the receiver stalls, the character in the output register holds and
// emission pauses. Reset clears the sequencer and output valid; no request
// or character is pending after reset.
// ----------------------------------------------------------------------------
module integer_to_ascii_converter_unit
    import itoa_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         req_type,
    input  logic [VALUE_W-1:0] value_bits,
    input  logic [7:0]         radix,
    input  logic [7:0]         pad_width,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [7:0]         char_code,
    output logic               last_char
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic              neg_reg, neg_next;
    logic              fixed_reg, fixed_next;
    logic [IDX_W-1:0]  width_reg, width_next;
    logic [DIG_W-1:0]  base_reg, base_next;
    logic [NDIG_W-1:0] ndig_reg, ndig_next;
    logic [IDX_W-1:0]  len_reg, len_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [DIG_W-1:0]  dig_reg [VALUE_W];

    logic              out_valid_reg, out_valid_next;
    logic [7:0]        char_reg, char_next;
    logic              last_reg, last_next;

    div_req_t          div_req;
    div_rsp_t          div_rsp;

    logic              accept;
    logic              neg_in;
    logic [VALUE_W-1:0] mag_in;
    logic              req_ok;
    logic [DIG_W-1:0]  base_in;
    logic              push;
    logic [NDIG_W-1:0] ndig_inc;
    logic [IDX_W-1:0]  len_full;
    logic              emit_fire;
    logic [7:0]        emit_char;

    itoa_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;

    // Request decode
    always_comb
    begin
        neg_in  = value_bits[VALUE_W-1];
        mag_in  = value_bits;
        base_in = DEC_BASE;
        req_ok  = 1'b0;
        case (req_type)
            MODE_DEC:
            begin
                req_ok = 1'b1;
                if (neg_in)
                    mag_in = '0 - value_bits;
            end
            MODE_FIXED:
            begin
                req_ok = (pad_width != 8'd0) && (9'(pad_width) < 9'(MAX_WIDTH));
                if (neg_in)
                    mag_in = '0 - value_bits;
            end
            MODE_RADIX:
            begin
                req_ok  = (radix >= RADIX_MIN) && (radix <= RADIX_MAX);
                base_in = radix[DIG_W-1:0];
                neg_in  = 1'b0;
            end
            default:
            begin
                req_ok = 1'b0;
            end
        endcase
    end

    // Digit bookkeeping
    assign push     = (state_reg == ST_DIV) && div_rsp.done;
    assign ndig_inc = ndig_reg + 1'b1;
    assign len_full = IDX_W'(ndig_inc) + IDX_W'(neg_reg);

    // Character at the current index: padding, sign or digit
    always_comb
    begin
        if (idx_reg >= len_reg)
            emit_char = CH_SPACE;
        else if (neg_reg && (idx_reg == len_reg - 1'b1))
            emit_char = CH_MINUS;
        else
            emit_char = digit_char(dig_reg[idx_reg[SLOT_W-1:0]]);
    end

    assign emit_fire = (state_reg == ST_EMIT) && (!out_valid_reg || !out_stall);

    // Sequencer
    always_comb
    begin
        state_next       = state_reg;
        neg_next         = neg_reg;
        fixed_next       = fixed_reg;
        width_next       = width_reg;
        base_next        = base_reg;
        ndig_next        = ndig_reg;
        len_next         = len_reg;
        idx_next         = idx_reg;
        div_req.start    = 1'b0;
        div_req.dividend = mag_in;
        div_req.divisor  = base_in;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && req_ok)
                begin
                    neg_next      = neg_in;
                    fixed_next    = (req_type == MODE_FIXED);
                    width_next    = IDX_W'(pad_width);
                    base_next     = base_in;
                    ndig_next     = '0;
                    div_req.start = 1'b1;
                    state_next    = ST_DIV;
                end
            end
            ST_DIV:
            begin
                // base held from the accepted request
                div_req.dividend = div_rsp.quotient;
                div_req.divisor  = base_reg;
                if (div_rsp.done)
                begin
                    ndig_next = ndig_inc;
                    if (div_rsp.quotient == '0)
                    begin
                        len_next   = len_full;
                        idx_next   = (fixed_reg ? width_reg : len_full) - 1'b1;
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        div_req.start = 1'b1;
                    end
                end
            end
            ST_EMIT:
            begin
                if (emit_fire)
                begin
                    if (idx_reg == '0)
                        state_next = ST_IDLE;
                    else
                        idx_next = idx_reg - 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output register
    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        char_next      = char_reg;
        last_next      = last_reg;
        if (emit_fire)
        begin
            out_valid_next = 1'b1;
            char_next      = emit_char;
            last_next      = (idx_reg == '0);
        end
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Request context and output payload
    always_ff @(posedge clk)
    begin
        neg_reg   <= neg_next;
        fixed_reg <= fixed_next;
        width_reg <= width_next;
        base_reg  <= base_next;
        ndig_reg  <= ndig_next;
        len_reg   <= len_next;
        idx_reg   <= idx_next;
        char_reg  <= char_next;
        last_reg  <= last_next;
    end

    // Digit store, least significant digit at slot zero
    always_ff @(posedge clk)
    begin
        if (push)
            dig_reg[ndig_reg[SLOT_W-1:0]] <= div_rsp.remainder;
    end

    assign out_valid = out_valid_reg;
    assign char_code = char_reg;
    assign last_char = last_reg;

endmodule
